FILE: hw/rtl/sfbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfbm_pkg: shared types and constants of the fractal simplex height core
// Field widths, fixed-point constants, the permutation table and the bus
// structures that run along the octave chain.
// ----------------------------------------------------------------------------
package sfbm_pkg;

  localparam int GRID_W   = 11;
  localparam int IDX_W    = 10;
  localparam int OFF_W    = 32;
  localparam int SCALE_W  = 24;
  localparam int OCT_W    = 4;
  localparam int PERS_W   = 18;
  localparam int LAC_W    = 20;
  localparam int HEIGHT_W = 17;
  localparam int U_W      = IDX_W + SCALE_W;
  localparam int FACT_W   = 24;
  localparam int TOTAL_W  = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CELL_LAT = 16;

  localparam logic [FACT_W-1:0] FACT_ONE = 24'd65536;
  localparam logic [FACT_W-1:0] FACT_MAX = 24'hFFFFFF;

  localparam logic signed [15:0] SKEW_F2   = 16'sd23988;
  localparam logic signed [15:0] UNSKEW_G2 = 16'sd13849;
  localparam logic signed [15:0] UNSKEW_G2X2 = 16'sd27698;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_COORD_SCALE,
    REG_OCTAVE_COUNT,
    REG_PERSISTENCE,
    REG_LACUNARITY
  } reg_idx_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic [PERS_W-1:0]       persistence;
    logic [LAC_W-1:0]        lacunarity;
  } sfbm_cfg_t;

  typedef struct packed {
    logic                      valid;
    logic [OCT_W-1:0]          rem;
    logic [U_W-1:0]            ux;
    logic [U_W-1:0]            uy;
    logic [FACT_W-1:0]         freq;
    logic [FACT_W-1:0]         amp;
    logic signed [TOTAL_W-1:0] total;
  } sfbm_bus_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage
`default_nettype wire

FILE: hw/rtl/sfbm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfbm_div: pipelined restoring divider, two lanes sharing one divisor
// One quotient bit per stage; the octave count travels alongside as a tag.
// ----------------------------------------------------------------------------
module sfbm_div
  import sfbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [OCT_W-1:0]  in_rem,
  input  wire logic [U_W-1:0]    num_x,
  input  wire logic [U_W-1:0]    num_y,
  input  wire logic [GRID_W-1:0] divisor,
  output logic                   out_valid,
  output logic [OCT_W-1:0]       out_rem,
  output logic [U_W-1:0]         quo_x,
  output logic [U_W-1:0]         quo_y
);

  logic [U_W-1:0]    qx [U_W+1];
  logic [U_W-1:0]    qy [U_W+1];
  logic [GRID_W-1:0] rx [U_W+1];
  logic [GRID_W-1:0] ry [U_W+1];
  logic              vld [U_W+1];
  logic [OCT_W-1:0]  rm [U_W+1];

  always_comb begin
    qx[0]  = num_x;
    qy[0]  = num_y;
    rx[0]  = '0;
    ry[0]  = '0;
    vld[0] = in_valid;
    rm[0]  = in_rem;
  end

  for (genvar k = 0; k < U_W; k++) begin : g_stage
    logic [GRID_W:0] tx;
    logic [GRID_W:0] ty;
    logic            bx;
    logic            by;

    always_comb begin
      tx = {rx[k], qx[k][U_W-1]};
      ty = {ry[k], qy[k][U_W-1]};
      bx = tx >= {1'b0, divisor};
      by = ty >= {1'b0, divisor};
    end

    always_ff @(posedge clk) begin
      rx[k+1] <= bx ? GRID_W'(tx - {1'b0, divisor}) : tx[GRID_W-1:0];
      ry[k+1] <= by ? GRID_W'(ty - {1'b0, divisor}) : ty[GRID_W-1:0];
      qx[k+1] <= {qx[k][U_W-2:0], bx};
      qy[k+1] <= {qy[k][U_W-2:0], by};
      rm[k+1] <= rm[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[U_W];
  assign out_rem   = rm[U_W];
  assign quo_x     = qx[U_W];
  assign quo_y     = qy[U_W];

endmodule
`default_nettype wire

FILE: hw/rtl/sfbm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfbm_cell: one octave of 2D simplex noise
// Scales the cell position, evaluates the noise in a 16-stage pipeline,
// adds the weighted value to the running total and steps frequency and
// amplitude for the next cell.
// ----------------------------------------------------------------------------
module sfbm_cell
  import sfbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sfbm_cfg_t cfg,
  input  wire sfbm_bus_t din,
  output sfbm_bus_t      dout
);

  localparam int SIDE_D = CELL_LAT - 1;

  // Side data delayed in step with the arithmetic stages.
  sfbm_bus_t sd [1:SIDE_D];

  logic [40:0]               pxl, pxh, pyl, pyh;
  logic signed [31:0]        x2r, y2r;
  logic signed [32:0]        sxy3;
  logic signed [31:0]        x3, y3;
  logic signed [31:0]        s4, x4, y4;
  logic signed [17:0]        ci5, cj5;
  logic [15:0]               fx5, fy5;
  logic signed [31:0]        s5;
  logic signed [33:0]        t6;
  logic [7:0]                ii6, pj0_6, pj1_6;
  logic [15:0]               fx6, fy6;
  logic signed [31:0]        s6;
  logic signed [18:0]        x0_7, y0_7;
  logic [7:0]                ii7, pj0_7, pj1_7;
  logic signed [18:0]        cx8 [3];
  logic signed [18:0]        cy8 [3];
  logic [3:0]                h8 [3];
  logic [36:0]               xx9 [3];
  logic [36:0]               yy9 [3];
  logic signed [20:0]        g9 [3];
  logic [15:0]               t16_10 [3];
  logic signed [20:0]        g10 [3];
  logic [14:0]               t2_11 [3];
  logic signed [20:0]        g11 [3];
  logic [12:0]               t4_12 [3];
  logic signed [20:0]        g12 [3];
  logic signed [33:0]        term13 [3];
  logic signed [24:0]        n14;
  logic signed [33:0]        w15;
  sfbm_bus_t                 dout_r;

  // Combinational values feeding each register stage.
  logic [47:0]               pxs, pys;
  logic signed [31:0]        x_c, y_c;
  logic signed [47:0]        sp_c;
  logic signed [33:0]        ax_c, ay_c;
  logic signed [18:0]        csum_c;
  logic signed [35:0]        x0w, y0w;
  logic                      i1;
  logic [7:0]                a0, a1, a2;
  logic signed [18:0]        cx_c [3];
  logic signed [18:0]        cy_c [3];
  logic signed [37:0]        sqx [3];
  logic signed [37:0]        sqy [3];
  logic signed [20:0]        ue [3];
  logic signed [20:0]        ve [3];
  logic signed [38:0]        t32 [3];
  logic [31:0]               p11 [3];
  logic [29:0]               p12 [3];
  logic signed [35:0]        sum_c;
  logic signed [40:0]        s24_c;
  logic signed [49:0]        wp_c;
  logic [43:0]               fp_c;
  logic [41:0]               ap_c;
  logic [27:0]               fq_c;
  logic [25:0]               aq_c;

  always_comb begin
    pxs    = (48'(pxh) << 17) + 48'(pxl);
    pys    = (48'(pyh) << 17) + 48'(pyl);
    x_c    = cfg.offset_x + $signed(pxs[47:16]);
    y_c    = cfg.offset_y + $signed(pys[47:16]);
    sp_c   = 48'(sxy3) * 48'(SKEW_F2);
    ax_c   = 34'(x4) + 34'(s4);
    ay_c   = 34'(y4) + 34'(s4);
    csum_c = 19'(ci5) + 19'(cj5);
    x0w    = 36'($signed({1'b0, fx6})) - 36'(s6) + 36'(t6);
    y0w    = 36'($signed({1'b0, fy6})) - 36'(s6) + 36'(t6);

    // Middle corner: step along x when the point lies below the diagonal.
    i1     = x0_7 > y0_7;
    cx_c[0] = x0_7;
    cy_c[0] = y0_7;
    cx_c[1] = x0_7 - (i1 ? 19'sd65536 : 19'sd0) + 19'(UNSKEW_G2);
    cy_c[1] = y0_7 - (i1 ? 19'sd0 : 19'sd65536) + 19'(UNSKEW_G2);
    cx_c[2] = x0_7 - 19'sd65536 + 19'(UNSKEW_G2X2);
    cy_c[2] = y0_7 - 19'sd65536 + 19'(UNSKEW_G2X2);
    a0 = ii7 + pj0_7;
    a1 = ii7 + 8'(i1) + (i1 ? pj0_7 : pj1_7);
    a2 = ii7 + 8'd1 + pj1_7;

    for (int c = 0; c < 3; c++) begin
      sqx[c] = 38'(cx8[c]) * 38'(cx8[c]);
      sqy[c] = 38'(cy8[c]) * 38'(cy8[c]);
      ue[c]  = h8[c][3] ? 21'(cy8[c]) : 21'(cx8[c]);
      ve[c]  = h8[c][3] ? 21'(cx8[c]) : 21'(cy8[c]);
      t32[c] = 39'sd2147483648 - $signed({2'b00, xx9[c]}) - $signed({2'b00, yy9[c]});
      p11[c] = 32'(t16_10[c]) * 32'(t16_10[c]);
      p12[c] = 30'(t2_11[c]) * 30'(t2_11[c]);
    end

    sum_c = 36'(term13[0]) + 36'(term13[1]) + 36'(term13[2]);
    s24_c = (41'(sum_c) <<< 4) + (41'(sum_c) <<< 3);
    wp_c  = 50'(n14) * 50'($signed({1'b0, sd[14].amp}));

    fp_c = 44'(sd[SIDE_D].freq) * 44'(cfg.lacunarity);
    ap_c = 42'(sd[SIDE_D].amp) * 42'(cfg.persistence);
    fq_c = fp_c[43:16];
    aq_c = ap_c[41:16];
  end

  always_ff @(posedge clk) begin
    pxl  <= 41'(din.ux[16:0]) * 41'(din.freq);
    pxh  <= 41'(din.ux[U_W-1:17]) * 41'(din.freq);
    pyl  <= 41'(din.uy[16:0]) * 41'(din.freq);
    pyh  <= 41'(din.uy[U_W-1:17]) * 41'(din.freq);

    x2r  <= x_c;
    y2r  <= y_c;

    sxy3 <= 33'(x2r) + 33'(y2r);
    x3   <= x2r;
    y3   <= y2r;

    s4   <= sp_c[47:16];
    x4   <= x3;
    y4   <= y3;

    ci5  <= ax_c[33:16];
    cj5  <= ay_c[33:16];
    fx5  <= ax_c[15:0];
    fy5  <= ay_c[15:0];
    s5   <= s4;

    t6    <= 34'(csum_c) * 34'(UNSKEW_G2);
    ii6   <= ci5[7:0];
    pj0_6 <= PERM_ROM[cj5[7:0]];
    pj1_6 <= PERM_ROM[8'(cj5[7:0] + 8'd1)];
    fx6   <= fx5;
    fy6   <= fy5;
    s6    <= s5;

    x0_7  <= x0w[18:0];
    y0_7  <= y0w[18:0];
    ii7   <= ii6;
    pj0_7 <= pj0_6;
    pj1_7 <= pj1_6;

    h8[0] <= PERM_ROM[a0][3:0];
    h8[1] <= PERM_ROM[a1][3:0];
    h8[2] <= PERM_ROM[a2][3:0];

    for (int c = 0; c < 3; c++) begin
      cx8[c]    <= cx_c[c];
      cy8[c]    <= cy_c[c];
      xx9[c]    <= sqx[c][36:0];
      yy9[c]    <= sqy[c][36:0];
      g9[c]     <= (h8[c][0] ? -ue[c] : ue[c]) + (h8[c][1] ? -(ve[c] + ve[c]) : (ve[c] + ve[c]));
      t16_10[c] <= t32[c][38] ? 16'd0 : t32[c][31:16];
      g10[c]    <= g9[c];
      t2_11[c]  <= p11[c][30:16];
      g11[c]    <= g10[c];
      t4_12[c]  <= p12[c][28:16];
      g12[c]    <= g11[c];
      term13[c] <= 34'($signed({1'b0, t4_12[c]})) * 34'(g12[c]);
    end

    n14 <= s24_c[40:16];
    w15 <= wp_c[49:16];

    dout_r.rem   <= (sd[SIDE_D].rem != '0) ? sd[SIDE_D].rem - 1'b1 : '0;
    dout_r.ux    <= sd[SIDE_D].ux;
    dout_r.uy    <= sd[SIDE_D].uy;
    dout_r.freq  <= (fq_c > 28'(FACT_MAX)) ? FACT_MAX : fq_c[FACT_W-1:0];
    dout_r.amp   <= (aq_c > 26'(FACT_MAX)) ? FACT_MAX : aq_c[FACT_W-1:0];
    dout_r.total <= sd[SIDE_D].total +
                    ((sd[SIDE_D].rem != '0) ? TOTAL_W'(w15) : '0);

    if (rst) begin
      for (int k = 1; k <= SIDE_D; k++) begin
        sd[k].valid <= 1'b0;
      end
      dout_r.valid <= 1'b0;
    end else begin
      sd[1] <= din;
      for (int k = 2; k <= SIDE_D; k++) begin
        sd[k] <= sd[k-1];
      end
      dout_r.valid <= sd[SIDE_D].valid;
    end
  end

  assign dout = dout_r;

endmodule
`default_nettype wire

FILE: hw/rtl/simplex_noise_fbm_height_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_noise_fbm_height_core: fractal 2D simplex noise height generator
// Turns a map cell (row, column) into a clamped Q1.16 height by summing
// up to MAX_OCTAVES octaves of fixed-point simplex noise.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low; row and column are sampled there. Busy is high during reset and in the
// first cycle after it and low otherwise, so a new request may be issued on
// every cycle. Each request yields one result: height is valid while done is
// high, for exactly one cycle. The receiver cannot stall the block, and
// results leave in request order.
//
// A request passes in order through a register that forms column*coord_scale,
// the pipelined divider by grid_size (one quotient bit per stage), the octave
// cells of 16 stages each, and a register that forms the clamped height and
// done. Throughput is one request per cycle.
//
// Configuration writes land when cfg_valid and cfg_ready are both high and
// must only happen while no request is in flight. Reset restores the default
// register values and flushes all in-flight requests.
// ----------------------------------------------------------------------------
module simplex_noise_fbm_height_core
  import sfbm_pkg::*;
#(
  parameter int MAX_GRID    = 1024,
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [IDX_W-1:0]     row,
  input  wire logic [IDX_W-1:0]     column,
  output logic                      done,
  output logic [HEIGHT_W-1:0]       height,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Clamp limits; the grid register cannot exceed 2047 anyway.
  localparam logic [GRID_W:0] GRID_CAP =
    (MAX_GRID > 2047) ? 12'd2047 : 12'(MAX_GRID);
  localparam logic [OCT_W:0]  OCT_CAP =
    (MAX_OCTAVES > 15) ? 5'd15 : 5'(MAX_OCTAVES);

  // Configuration registers.
  logic [GRID_W-1:0]        grid_size;
  logic signed [OFF_W-1:0]  offset_x;
  logic signed [OFF_W-1:0]  offset_y;
  logic [SCALE_W-1:0]       coord_scale;
  logic [OCT_W-1:0]         octave_count;
  logic [PERS_W-1:0]        persistence;
  logic [LAC_W-1:0]         lacunarity;

  logic [GRID_W-1:0]        grid_eff;
  logic [OCT_W-1:0]         oct_eff;

  // Front stage: product of the cell index and the map span.
  logic                     in_valid;
  logic [OCT_W-1:0]         in_rem;
  logic [U_W-1:0]           prod_x;
  logic [U_W-1:0]           prod_y;

  sfbm_cfg_t                cell_cfg;
  sfbm_bus_t                chain [MAX_OCTAVES+1];

  logic                     div_valid;
  logic [OCT_W-1:0]         div_rem;
  logic [U_W-1:0]           div_x;
  logic [U_W-1:0]           div_y;

  logic signed [TOTAL_W:0]   hsum;
  logic signed [TOTAL_W-1:0] hhalf;

  // A zero grid size acts as one; larger sizes saturate at the cap.
  always_comb begin
    if (grid_size == '0) begin
      grid_eff = GRID_W'(1);
    end else if ({1'b0, grid_size} > GRID_CAP) begin
      grid_eff = GRID_CAP[GRID_W-1:0];
    end else begin
      grid_eff = grid_size;
    end
    oct_eff = ({1'b0, octave_count} > OCT_CAP) ? OCT_CAP[OCT_W-1:0] : octave_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      in_valid     <= 1'b0;
      done         <= 1'b0;
      grid_size    <= 11'd256;
      offset_x     <= '0;
      offset_y     <= '0;
      coord_scale  <= 24'd65536;
      octave_count <= 4'd4;
      persistence  <= 18'd32768;
      lacunarity   <= 20'd131072;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= chain[MAX_OCTAVES].valid;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_GRID_SIZE:    grid_size    <= cfg_data[GRID_W-1:0];
          REG_OFFSET_X:     offset_x     <= $signed(cfg_data);
          REG_OFFSET_Y:     offset_y     <= $signed(cfg_data);
          REG_COORD_SCALE:  coord_scale  <= cfg_data[SCALE_W-1:0];
          REG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_W-1:0];
          REG_PERSISTENCE:  persistence  <= cfg_data[PERS_W-1:0];
          REG_LACUNARITY:   lacunarity   <= cfg_data[LAC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    prod_x <= U_W'(column) * U_W'(coord_scale);
    prod_y <= U_W'(row) * U_W'(coord_scale);
    in_rem <= oct_eff;
  end

  // Cell position in noise space before the per-octave frequency.
  sfbm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_rem    (in_rem),
    .num_x     (prod_x),
    .num_y     (prod_y),
    .divisor   (grid_eff),
    .out_valid (div_valid),
    .out_rem   (div_rem),
    .quo_x     (div_x),
    .quo_y     (div_y)
  );

  always_comb begin
    cell_cfg.offset_x    = offset_x;
    cell_cfg.offset_y    = offset_y;
    cell_cfg.persistence = persistence;
    cell_cfg.lacunarity  = lacunarity;

    // Octave chain entry: unit frequency and amplitude, empty total.
    chain[0].valid = div_valid;
    chain[0].rem   = div_rem;
    chain[0].ux    = div_x;
    chain[0].uy    = div_y;
    chain[0].freq  = FACT_ONE;
    chain[0].amp   = FACT_ONE;
    chain[0].total = '0;
  end

  // Each cell adds its octave while its remaining count is nonzero; cells
  // past the configured count pass the total through unchanged.
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    sfbm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cell_cfg),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Map [-1,1] onto [0,1] with a floor halving, then clamp.
  always_comb begin
    hsum  = (TOTAL_W+1)'(chain[MAX_OCTAVES].total) + 41'sd65536;
    hhalf = hsum[TOTAL_W:1];
  end

  always_ff @(posedge clk) begin
    if (hhalf[TOTAL_W-1]) begin
      height <= '0;
    end else if (hhalf > 40'sd65536) begin
      height <= 17'd65536;
    end else begin
      height <= hhalf[HEIGHT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  localparam int CHECK_LAT = 2 + U_W + CELL_LAT * MAX_OCTAVES;

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !busy)
    else $error("busy high outside the cycle after reset");

  a_done_matches_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, CHECK_LAT))
    else $error("result without a matching request");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    done |-> height <= 17'd65536)
    else $error("height beyond one");
`endif

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for simplex_noise_fbm_height_core
// Drives map cells through the core under several register settings, some
// directed and some random, and compares every height with a fixed-point
// fractal simplex noise calculation kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  import sfbm_pkg::*;

  // Register index that the core has no register for; a write to it must
  // leave every setting as it was.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Idle cycles the drain task waits after the last outstanding height.
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;

  // Tracks register settings, predicts heights for accepted requests and
  // matches them against the results in order.
  class height_scoreboard;
    logic [10:0] grid_size;
    longint      offset_x, offset_y;
    logic [23:0] coord_scale;
    logic [3:0]  octave_count;
    logic [17:0] persistence;
    logic [19:0] lacunarity;
    logic [16:0] pending_heights[$];
    int          failures;
    int          checked;

    function new();
      grid_size = 11'd256; offset_x = 0; offset_y = 0;
      coord_scale = 24'd65536; octave_count = 4'd4;
      persistence = 18'd32768; lacunarity = 20'd131072;
      failures = 0; checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_GRID_SIZE:    grid_size = data[10:0];
        REG_OFFSET_X:     offset_x = longint'($signed(data));
        REG_OFFSET_Y:     offset_y = longint'($signed(data));
        REG_COORD_SCALE:  coord_scale = data[23:0];
        REG_OCTAVE_COUNT: octave_count = data[3:0];
        REG_PERSISTENCE:  persistence = data[17:0];
        REG_LACUNARITY:   lacunarity = data[19:0];
        default: ;
      endcase
    endfunction

    static function longint wrap32(longint v);
      return longint'($signed(v[31:0]));
    endfunction

    // One corner of the simplex: radial falloff to the fourth power times the
    // gradient dot product, all in Q32.
    static function longint corner(longint x, longint y, int unsigned h);
      longint t32, t16, t2, t4, u, v, g;
      t32 = 64'sd2147483648 - x * x - y * y;
      if (t32 < 0) return 0;
      t16 = t32 >>> 16;
      t2 = (t16 * t16) >>> 16;
      t4 = (t2 * t2) >>> 16;
      h = h & 15;
      u = (h < 8) ? x : y;
      v = (h < 8) ? y : x;
      g = (((h & 1) != 0) ? -u : u) + (((h & 2) != 0) ? -2 * v : 2 * v);
      return t4 * g;
    endfunction

    static function longint simplex(longint x, longint y);
      longint s, ci, cj, t, x0, y0, x1, y1, x2, y2, sum;
      int unsigned i1, j1, ii, jj, h0, h1, h2;
      s = ((x + y) * 64'sd23988) >>> 16;
      ci = (x + s) >>> 16;
      cj = (y + s) >>> 16;
      t = (ci + cj) * 64'sd13849;
      x0 = x - (ci * 65536 - t);
      y0 = y - (cj * 65536 - t);
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      x1 = x0 - longint'(i1) * 65536 + 13849;
      y1 = y0 - longint'(j1) * 65536 + 13849;
      x2 = x0 - 65536 + 2 * 13849;
      y2 = y0 - 65536 + 2 * 13849;
      ii = int'(ci & 255);
      jj = int'(cj & 255);
      h0 = PERM_ROM[(ii + PERM_ROM[jj]) & 255];
      h1 = PERM_ROM[(ii + i1 + PERM_ROM[(jj + j1) & 255]) & 255];
      h2 = PERM_ROM[(ii + 1 + PERM_ROM[(jj + 1) & 255]) & 255];
      sum = corner(x0, y0, h0) + corner(x1, y1, h1) + corner(x2, y2, h2);
      return (sum * 24) >>> 16;
    endfunction

    function logic [16:0] predict_height(logic [9:0] r, logic [9:0] c);
      longint unsigned g, ux, uy;
      longint freq, amp, total, x, y, n, h;
      int oct;
      g = grid_size;
      if (g == 0) g = 1;
      if (g > 1024) g = 1024;
      oct = (octave_count > 8) ? 8 : int'(octave_count);
      ux = (longint'(c) * longint'(coord_scale)) / g;
      uy = (longint'(r) * longint'(coord_scale)) / g;
      freq = 65536; amp = 65536; total = 0;
      for (int k = 0; k < oct; k++) begin
        x = wrap32(offset_x + longint'((ux * longint'(freq)) >> 16));
        y = wrap32(offset_y + longint'((uy * longint'(freq)) >> 16));
        n = simplex(x, y);
        total += (n * amp) >>> 16;
        amp = (amp * longint'(persistence)) >>> 16;
        if (amp > 64'hFFFFFF) amp = 64'hFFFFFF;
        freq = (freq * longint'(lacunarity)) >>> 16;
        if (freq > 64'hFFFFFF) freq = 64'hFFFFFF;
      end
      h = (total + 65536) >>> 1;
      if (h < 0) h = 0;
      if (h > 65536) h = 65536;
      return h[16:0];
    endfunction

    function void note_cell(logic [9:0] r, logic [9:0] c);
      pending_heights.push_back(predict_height(r, c));
    endfunction

    function void check_height(logic [16:0] actual);
      logic [16:0] want;
      checked++;
      if (pending_heights.size() == 0) begin
        $error("height %0d arrived with no request outstanding", actual);
        failures++;
        return;
      end
      want = pending_heights.pop_front();
      if (actual !== want) begin
        $error("height mismatch: expected %0d, actual %0d", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic                 clk, rst;
  logic                 start, busy;
  logic [IDX_W-1:0]     row, column;
  logic                 done;
  logic [HEIGHT_W-1:0]  height;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  height_scoreboard sb = new();
  int accepted_requests = 0;
  int accepted_writes = 0;
  int cycles = 0;
  int idle_pct = 0;

  simplex_noise_fbm_height_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .row(row), .column(column),
    .done(done), .height(height), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Everything is sampled at the rising edge, before the core's registers
  // update, so no result depends on event order within the step.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        sb.note_cell(row, column);
        accepted_requests <= accepted_requests + 1;
      end
      if (done) sb.check_height(height);
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        accepted_writes <= accepted_writes + 1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[simplex_noise_fbm_height_core] ERROR");
      $finish;
    end
  end

  // Presents one request from a falling edge and holds it until the core
  // takes it. Before presenting, each cycle is left idle with a chance of
  // idle_pct in a hundred. Start stays high on return so back-to-back
  // requests need no second assignment.
  task automatic issue_cell(logic [9:0] r, logic [9:0] c);
    int target;
    target = accepted_requests + 1;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    row = r;
    column = c;
    do @(negedge clk); while (accepted_requests < target);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    int target;
    target = accepted_writes + 1;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(negedge clk); while (accepted_writes < target);
    cfg_valid = 1'b0;
  endtask

  // Waits for every outstanding height, then lets the pipeline run empty so
  // that a register change cannot reach a request still in flight.
  task automatic drain();
    start = 1'b0;
    while (sb.pending_heights.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(logic [31:0] grid, logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] scale, logic [31:0] oct,
                               logic [31:0] pers, logic [31:0] lac);
    write_reg(REG_GRID_SIZE, grid);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_COORD_SCALE, scale);
    write_reg(REG_OCTAVE_COUNT, oct);
    write_reg(REG_PERSISTENCE, pers);
    write_reg(REG_LACUNARITY, lac);
  endtask

  // Random cells: mostly inside the map, some anywhere in the index range.
  task automatic random_cells(int count);
    logic [9:0] r, c;
    int lim;
    lim = (sb.grid_size == 0) ? 0 : ((sb.grid_size > 1024) ? 1023 : sb.grid_size - 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        r = $urandom;
        c = $urandom;
      end else begin
        r = $urandom_range(lim);
        c = $urandom_range(lim);
      end
      issue_cell(r, c);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    row = '0;
    column = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_SIZE;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with reset settings: the corners of the index range and two inner cells.
    idle_pct = 15;
    issue_cell(10'd0, 10'd0);
    issue_cell(10'd1023, 10'd1023);
    issue_cell(10'd0, 10'd1023);
    issue_cell(10'd1023, 10'd0);
    issue_cell(10'd255, 10'd256);
    issue_cell(10'h2AA, 10'h155);
    drain();

    // Zero grid size acts as one, extreme negative offsets, full scale,
    // octave count past the maximum and the largest factors so both
    // frequency and amplitude saturate. The unused index must be ignored.
    load_settings(32'd0, 32'h8000_0000, 32'h8000_0000, 32'hFF_FFFF, 32'd15,
                  32'h3_FFFF, 32'hF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    issue_cell(10'd0, 10'd0);
    issue_cell(10'd1023, 10'd1023);
    issue_cell(10'd1, 10'd512);
    drain();

    // Oversized grid saturates, largest positive offsets, zero scale.
    load_settings(32'd2047, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd8, 32'd0, 32'd0);
    issue_cell(10'd1023, 10'd0);
    issue_cell(10'd17, 10'd900);
    drain();

    // No octaves at all: every height sits at mid level.
    load_settings(32'd1024, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd32768, 32'd131072);
    issue_cell(10'd1023, 10'd1023);
    issue_cell(10'd3, 10'd7);
    drain();

    // Random part in three thirds: sender gaps rare, then frequent, then none.
    for (int ph = 0; ph < 6; ph++) begin
      load_settings($urandom_range(2047), $urandom, $urandom, $urandom_range(24'hFF_FFFF),
                    $urandom_range(15), $urandom_range(18'h3_FFFF),
                    $urandom_range(20'hF_FFFF));
      if (ph % 2 == 0) begin
        // Keep grid and factors in a typical range for half the phases.
        write_reg(REG_GRID_SIZE, $urandom_range(1, 1024));
        write_reg(REG_COORD_SCALE, $urandom_range(1 << 20));
        write_reg(REG_PERSISTENCE, $urandom_range(65536));
        write_reg(REG_LACUNARITY, $urandom_range(65536, 196608));
      end
      idle_pct = (ph < 2) ? 15 : ((ph < 4) ? 64 : 0);
      random_cells(150);
      drain();
    end

    $display("Covered %0d cells and %0d register writes over directed and random settings.",
             accepted_requests, accepted_writes);
    $display("Checked %0d heights in %0d cycles.", sb.checked, cycles);
    if (sb.failures == 0 && sb.pending_heights.size() == 0) begin
      $display("[simplex_noise_fbm_height_core] OK");
    end else begin
      $display("[simplex_noise_fbm_height_core] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/sfbm_pkg.sv
hw/rtl/sfbm_div.sv
hw/rtl/sfbm_cell.sv
hw/rtl/simplex_noise_fbm_height_core.sv
bench/testbench.sv
